>>> hw/rtl/bclsu_pkg.sv
// ----------------------------------------------------------------------------
// bclsu_pkg
// Shared constants, command codes and types of the bicolour column scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bclsu_pkg;

   // default number of chained 8x8 matrices
   localparam int MatrixCountDefault = 5;

   // request selector codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_SCAN  = 2'd1;
   localparam logic [1:0] OP_BLANK = 2'd2;

   // command codes between front and back
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_SCAN  = 2'd1;
   localparam logic [1:0] CMD_BLANK = 2'd2;

   localparam logic [7:0] PixelValueMax = 8'd3;
   localparam logic [7:0] BlankHeadByte = 8'hFF;

   // command queue depth, power of two
   localparam int QueueDepth = 2;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] matrix;
      logic [2:0] row;
      logic [2:0] col;
      logic [1:0] pixel;
   } cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/bclsu_if.sv
// ----------------------------------------------------------------------------
// bclsu_if
// Valid/ready channel interfaces for requests and response bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bclsu_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [8:0] pixel_address;
   logic [7:0] pixel_value;
   logic [2:0] column;

   modport source (output valid, output op, output pixel_address,
                   output pixel_value, output column, input ready);
   modport sink   (input valid, input op, input pixel_address,
                   input pixel_value, input column, output ready);
endinterface

interface bclsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] spi_byte;
   logic       last;

   modport source (output valid, output spi_byte, output last, input ready);
   modport sink   (input valid, input spi_byte, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bclsu_front.sv
// ----------------------------------------------------------------------------
// bclsu_front
// Accepts request items, classifies them and pushes commands to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bclsu_front #(
   parameter int MATRIX_COUNT = bclsu_pkg::MatrixCountDefault
) (
   input  wire                 clock,
   input  wire                 reset,
   bclsu_req_if.sink           req,
   input  wire                 clearing,
   output logic                push_valid,
   input  wire                 push_ready,
   output bclsu_pkg::cmd_type  push_cmd
);

   localparam int StoreDepth = MATRIX_COUNT * 64;

   logic keep;
   logic addr_ok;

   assign req.ready = !clearing && push_ready;
   assign addr_ok   = 32'(req.pixel_address) < 32'(StoreDepth);

   always_comb begin
      push_cmd        = '0;
      keep            = 1'b0;
      push_cmd.matrix = req.pixel_address[8:6];
      push_cmd.row    = req.pixel_address[5:3];
      push_cmd.col    = req.pixel_address[2:0];
      // values above 3 land as blank
      push_cmd.pixel  = (req.pixel_value <= bclsu_pkg::PixelValueMax) ?
                        req.pixel_value[1:0] : 2'd0;
      unique case (req.op)
         bclsu_pkg::OP_WRITE: begin
            push_cmd.kind = bclsu_pkg::CMD_WRITE;
            keep          = addr_ok;
         end
         bclsu_pkg::OP_SCAN: begin
            push_cmd.kind = bclsu_pkg::CMD_SCAN;
            push_cmd.col  = req.column;
            keep          = 1'b1;
         end
         bclsu_pkg::OP_BLANK: begin
            push_cmd.kind = bclsu_pkg::CMD_BLANK;
            keep          = 1'b1;
         end
         default: begin
            push_cmd.kind = bclsu_pkg::CMD_WRITE;
            keep          = 1'b0;
         end
      endcase
   end

   assign push_valid = req.valid && req.ready && keep;

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !push_valid)
      else $error("command pushed during clearing pass");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("command pushed into full queue");

   a_bad_write_dropped: assert property (@(posedge clock) disable iff (reset)
      (req.op == bclsu_pkg::OP_WRITE && !addr_ok) |-> !push_valid)
      else $error("out of range write reached the queue");

endmodule

`default_nettype wire

>>> hw/rtl/bclsu_queue.sv
// ----------------------------------------------------------------------------
// bclsu_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bclsu_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push_valid,
   output logic                push_ready,
   input  bclsu_pkg::cmd_type  push_cmd,
   output logic                pop_valid,
   input  wire                 pop_ready,
   output bclsu_pkg::cmd_type  pop_cmd
);

   localparam int PtrWidth = (bclsu_pkg::QueueDepth > 1) ?
                             $clog2(bclsu_pkg::QueueDepth) : 1;
   localparam int CntWidth = $clog2(bclsu_pkg::QueueDepth + 1);

   bclsu_pkg::cmd_type entry_ff [bclsu_pkg::QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != CntWidth'(bclsu_pkg::QueueDepth);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == bclsu_pkg::QueueDepth - 1) ? '0 :
                     wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == bclsu_pkg::QueueDepth - 1) ? '0 :
                     rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= bclsu_pkg::QueueDepth)
      else $error("queue count overflow");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

   a_ptrs_meet_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree while empty");

endmodule

`default_nettype wire

>>> hw/rtl/bclsu_back.sv
// ----------------------------------------------------------------------------
// bclsu_back
// Frame store, clearing pass and the byte sequencer that builds each frame.
// ----------------------------------------------------------------------------
`default_nettype none

module bclsu_back #(
   parameter int MATRIX_COUNT = bclsu_pkg::MatrixCountDefault
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 pop_valid,
   output logic                pop_ready,
   input  bclsu_pkg::cmd_type  pop_cmd,
   output logic                clearing,
   bclsu_rsp_if.source         rsp
);

   localparam int MatWidth   = (MATRIX_COUNT > 1) ? $clog2(MATRIX_COUNT) : 1;
   localparam int AddrWidth  = MatWidth + 3;
   localparam int WordCount  = MATRIX_COUNT * 8;
   localparam int FrameBytes = 1 + 2 * MATRIX_COUNT;
   localparam int StepWidth  = $clog2(FrameBytes);

   // byte source of the read stage
   localparam logic [1:0] SRC_CONST = 2'd0;
   localparam logic [1:0] SRC_RED   = 2'd1;
   localparam logic [1:0] SRC_GREEN = 2'd2;

   function automatic logic [7:0] reverse8(input logic [7:0] v);
      logic [7:0] r;
      for (int k = 0; k < 8; k++) begin
         r[k] = v[7-k];
      end
      return r;
   endfunction

   // one word per matrix column: red rows in [15:8], green rows in [7:0]
   logic [15:0] store_mem [WordCount];
   logic [15:0] rd_data_ff;

   logic                 clear_ff;
   logic [AddrWidth-1:0] clear_cnt_ff;

   logic                 busy_ff, busy_in;
   logic [StepWidth-1:0] step_ff, step_in;
   logic [1:0]           kind_ff, kind_in;
   logic [2:0]           col_ff, col_in;

   logic       p_valid_ff, p_valid_in;
   logic [1:0] p_src_ff, p_src_in;
   logic [7:0] p_byte_ff, p_byte_in;
   logic       p_last_ff, p_last_in;

   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff;

   logic                 advance, issue, last_issue, rd_en, wr_en;
   logic                 load_cmd;
   logic [MatWidth-1:0]  rd_mat;
   logic [AddrWidth-1:0] rd_addr, wr_addr;

   assign clearing   = clear_ff;
   assign advance    = !rsp_valid_ff || rsp.ready;
   assign issue      = busy_ff && advance;
   assign last_issue = issue && (step_ff == StepWidth'(FrameBytes - 1));

   // writes wait until the current frame has issued all its reads
   always_comb begin
      pop_ready = 1'b0;
      if (!clear_ff && pop_valid) begin
         if (!busy_ff) begin
            pop_ready = 1'b1;
         end else if (last_issue && pop_cmd.kind != bclsu_pkg::CMD_WRITE) begin
            pop_ready = 1'b1;
         end
      end
   end

   assign load_cmd = pop_ready && pop_cmd.kind != bclsu_pkg::CMD_WRITE;
   assign wr_en    = pop_ready && pop_cmd.kind == bclsu_pkg::CMD_WRITE;
   assign wr_addr  = {MatWidth'(pop_cmd.matrix), pop_cmd.col};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      kind_in = kind_ff;
      col_in  = col_ff;
      if (load_cmd) begin
         busy_in = 1'b1;
         step_in = '0;
         kind_in = pop_cmd.kind;
         col_in  = pop_cmd.col;
      end else if (last_issue) begin
         busy_in = 1'b0;
      end else if (issue) begin
         step_in = step_ff + 1'b1;
      end
   end

   // read stage: work out the byte source for the current step
   always_comb begin
      p_valid_in = p_valid_ff;
      p_src_in   = p_src_ff;
      p_byte_in  = p_byte_ff;
      p_last_in  = p_last_ff;
      rd_en      = 1'b0;
      rd_mat     = '0;
      if (advance) begin
         p_valid_in = issue;
         p_src_in   = SRC_CONST;
         p_byte_in  = 8'd0;
         p_last_in  = step_ff == StepWidth'(FrameBytes - 1);
         if (kind_ff == bclsu_pkg::CMD_BLANK) begin
            if (step_ff == '0) begin
               p_byte_in = bclsu_pkg::BlankHeadByte;
            end
         end else if (step_ff == '0) begin
            p_byte_in = 8'h80 >> col_ff;
         end else if (32'(step_ff) <= MATRIX_COUNT) begin
            // red bytes run from the far matrix down
            p_src_in = SRC_RED;
            rd_mat   = MatWidth'(MATRIX_COUNT - 32'(step_ff));
            rd_en    = issue;
         end else begin
            p_src_in = SRC_GREEN;
            rd_mat   = MatWidth'(32'(step_ff) - MATRIX_COUNT - 1);
            rd_en    = issue;
         end
      end
   end

   assign rd_addr = {rd_mat, col_ff};

   always_comb begin
      unique case (p_src_ff)
         SRC_RED:   rsp_byte_in = reverse8(rd_data_ff[15:8]);
         SRC_GREEN: rsp_byte_in = rd_data_ff[7:0];
         default:   rsp_byte_in = p_byte_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         busy_ff      <= 1'b0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clear_ff && clear_cnt_ff == AddrWidth'(WordCount - 1)) begin
            clear_ff <= 1'b0;
         end
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
         busy_ff      <= busy_in;
         p_valid_ff   <= p_valid_in;
         if (advance) begin
            rsp_valid_ff <= p_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      kind_ff   <= kind_in;
      col_ff    <= col_in;
      p_src_ff  <= p_src_in;
      p_byte_ff <= p_byte_in;
      p_last_ff <= p_last_in;
      if (advance) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= p_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         store_mem[clear_cnt_ff] <= '0;
      end else if (wr_en) begin
         store_mem[wr_addr][8 + 32'(pop_cmd.row)] <= pop_cmd.pixel[1];
         store_mem[wr_addr][32'(pop_cmd.row)]     <= pop_cmd.pixel[0];
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.spi_byte = rsp_byte_ff;
   assign rsp.last     = rsp_last_ff;

   a_quiet_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> (!rsp_valid_ff && !busy_ff && !pop_ready))
      else $error("activity during clearing pass");

   a_no_write_in_frame: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !busy_ff)
      else $error("store written while a frame is reading");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> 32'(step_ff) <= FrameBytes - 1)
      else $error("frame step out of range");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (last_issue && !load_cmd) |=> !busy_ff)
      else $error("sequencer kept running past the final byte");

endmodule

`default_nettype wire

>>> hw/rtl/bicolor_led_matrix_column_scan_unit.sv
// ----------------------------------------------------------------------------
// bicolor_led_matrix_column_scan_unit
// Two-colour LED matrix column scan driver: frame store plus byte sequencer.
// ----------------------------------------------------------------------------
// first-byte path: an accepted item passes the command queue, the sequencer
// registers, the read stage and the output register
// throughput: one byte per cycle while the receiver is ready; each scan or
// blanking item gives 1 + 2*MATRIX_COUNT (11) bytes
// a pixel write waits until a frame in flight has issued all its reads
// reset: synchronous; a clearing pass zeroes all MATRIX_COUNT*8 (40) words of
// the store, and no item is taken until it ends
`default_nettype none

module bicolor_led_matrix_column_scan_unit #(
   parameter int MATRIX_COUNT = bclsu_pkg::MatrixCountDefault
) (
   input  wire          clock,
   input  wire          reset,
   bclsu_req_if.sink    req,
   bclsu_rsp_if.source  rsp
);

   logic               clearing;
   logic               push_valid, push_ready;
   logic               pop_valid, pop_ready;
   bclsu_pkg::cmd_type push_cmd, pop_cmd;

   bclsu_front #(
      .MATRIX_COUNT(MATRIX_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .clearing   (clearing),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   bclsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   bclsu_back #(
      .MATRIX_COUNT(MATRIX_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .clearing  (clearing),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

>>> tb/column_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_frame_checker
// Watches the request and byte channels of the column scan unit, keeps its
// own copy of the pixel store, works out the frame bytes each accepted item
// must produce and compares every accepted byte against the oldest one due.
// ----------------------------------------------------------------------------

module column_frame_checker (
   input  wire  clock,
   input  wire  reset,
   bclsu_req_if req_mon,
   bclsu_rsp_if rsp_mon,
   output int   mismatch_count,
   output int   bytes_due
);

   localparam int Matrices   = bclsu_pkg::MatrixCountDefault;
   localparam int StoreDepth = Matrices * 64;
   localparam int FrameLen   = 1 + 2 * Matrices;
   localparam int ReportMax  = 10;

   localparam logic [1:0] HueGreen = 2'd1;
   localparam logic [1:0] HueRed   = 2'd2;
   localparam logic [1:0] HueBoth  = 2'd3;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic       last;
   } frame_byte_type;

   frame_byte_type bytes_ahead[$];
   frame_byte_type due_byte;
   logic [1:0]     led_store [StoreDepth];
   int             errors = 0;

   // bit r set when row r of this column shows the hue
   function automatic logic [7:0] column_rows(int mat, logic [2:0] col, logic [1:0] hue);
      logic [7:0] rows;
      logic [1:0] px;
      rows = '0;
      for (int r = 0; r < 8; r++) begin
         px = led_store[mat * 64 + r * 8 + col];
         if (px == hue || px == HueBoth) rows[r] = 1'b1;
      end
      return rows;
   endfunction

   function automatic logic [7:0] mirror_byte(logic [7:0] v);
      logic [7:0] res;
      for (int k = 0; k < 8; k++) res[k] = v[7 - k];
      return res;
   endfunction

   task automatic predict_request(input logic [1:0] op, input logic [8:0] addr,
                                  input logic [7:0] val, input logic [2:0] col);
      logic [7:0] frame [FrameLen];
      bit         sends;
      sends = 1'b0;
      case (op)
         bclsu_pkg::OP_WRITE: begin
            if (addr < StoreDepth)
               led_store[addr] = (val <= bclsu_pkg::PixelValueMax) ? val[1:0] : 2'd0;
         end
         bclsu_pkg::OP_SCAN: begin
            sends = 1'b1;
            frame[0] = 8'd1 << (3'd7 - col);
            // red bytes run from the far matrix down, each mirrored
            for (int m = 0; m < Matrices; m++) begin
               frame[1 + m] = mirror_byte(column_rows(Matrices - 1 - m, col, HueRed));
               frame[1 + Matrices + m] = column_rows(m, col, HueGreen);
            end
         end
         bclsu_pkg::OP_BLANK: begin
            sends = 1'b1;
            frame[0] = bclsu_pkg::BlankHeadByte;
            for (int k = 1; k < FrameLen; k++) frame[k] = 8'd0;
         end
         default: ;
      endcase
      if (sends) begin
         for (int k = 0; k < FrameLen; k++)
            bytes_ahead.push_back('{spi_byte: frame[k], last: (k == FrameLen - 1)});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bytes_ahead.delete();
         for (int i = 0; i < StoreDepth; i++) led_store[i] = 2'd0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (bytes_ahead.size() == 0) begin
               errors++;
               if (errors <= ReportMax)
                  $display("%0t: unexpected byte %02h last %0d", $realtime,
                           rsp_mon.spi_byte, rsp_mon.last);
            end else begin
               due_byte = bytes_ahead.pop_front();
               if (due_byte.spi_byte !== rsp_mon.spi_byte ||
                   due_byte.last !== rsp_mon.last) begin
                  errors++;
                  if (errors <= ReportMax)
                     $display("%0t: byte mismatch, expected %02h last %0d, got %02h last %0d",
                              $realtime, due_byte.spi_byte, due_byte.last,
                              rsp_mon.spi_byte, rsp_mon.last);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_request(req_mon.op, req_mon.pixel_address, req_mon.pixel_value,
                            req_mon.column);
      end
      mismatch_count <= errors;
      bytes_due      <= bytes_ahead.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel writes, column scans, blanking frames and ignored items into
// the column scan unit under varying idle patterns and back-pressure, and
// reports the verdict of the frame checker.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int IdleLimit    = 3000;
   localparam int LongStall    = 300;
   localparam int SettleCycles = 20;
   localparam int PhaseItems   = 95;
   localparam int StallBurst   = 8;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int source_idle_pct = 34;
   int sink_idle_pct   = 70;
   int stalls_asked    = 0;
   int stalls_served   = 0;
   int hold_left       = 0;
   int quiet_cycles    = 0;
   int mismatch_count;
   int bytes_due;

   bclsu_req_if req_bus ();
   bclsu_rsp_if rsp_bus ();

   bicolor_led_matrix_column_scan_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   column_frame_checker frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .bytes_due      (bytes_due)
   );

   always #10 clock = ~clock;

   // stop the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // byte receiver: random idling plus long hold-offs on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stalls_served != stalls_asked) begin
            stalls_served++;
            hold_left = LongStall;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   task automatic offer_request(input logic [1:0] op, input logic [8:0] addr,
                                input logic [7:0] val, input logic [2:0] col);
      while ($urandom_range(99) < source_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.op            <= op;
      req_bus.pixel_address <= addr;
      req_bus.pixel_value   <= val;
      req_bus.column        <= col;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic offer_write(input logic [8:0] addr, input logic [7:0] val);
      offer_request(bclsu_pkg::OP_WRITE, addr, val, 3'($urandom_range(7)));
   endtask

   task automatic offer_scan(input logic [2:0] col);
      offer_request(bclsu_pkg::OP_SCAN, 9'($urandom_range(511)),
                    8'($urandom_range(255)), col);
   endtask

   task automatic offer_blank();
      offer_request(bclsu_pkg::OP_BLANK, 9'($urandom_range(511)),
                    8'($urandom_range(255)), 3'($urandom_range(7)));
   endtask

   // sender stays quiet until every frame byte due has come out
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (bytes_due != 0);
   endtask

   // ignored items (op 3, writes beyond the store) do not count
   task automatic offer_random_item(output bit counted);
      int pick;
      logic [7:0] val;
      pick = $urandom_range(99);
      counted = 1'b1;
      if (pick < 40) begin
         val = ($urandom_range(99) < 85) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
         offer_write(9'($urandom_range(319)), val);
      end else if (pick < 45) begin
         counted = 1'b0;
         offer_write(9'($urandom_range(511, 320)), 8'($urandom_range(255)));
      end else if (pick < 80) begin
         offer_scan(3'($urandom_range(7)));
      end else if (pick < 90) begin
         offer_blank();
      end else begin
         counted = 1'b0;
         offer_request(OP_UNUSED, 9'($urandom_range(511)), 8'($urandom_range(255)),
                       3'($urandom_range(7)));
      end
   endtask

   initial begin
      int  counted_items;
      bit  counted;
      req_bus.valid         = 1'b0;
      req_bus.op            = bclsu_pkg::OP_WRITE;
      req_bus.pixel_address = '0;
      req_bus.pixel_value   = '0;
      req_bus.column        = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // corners of the store, every colour, oversized values, ignored items
      offer_write(9'd0, 8'd3);
      offer_write(9'd319, 8'd2);
      offer_write(9'd7, 8'd1);
      offer_write(9'd56, 8'd3);
      offer_write(9'd63, 8'd2);
      offer_write(9'd256, 8'd1);
      offer_write(9'd320, 8'd3);
      offer_write(9'd511, 8'd2);
      offer_write(9'd64, 8'd4);
      offer_write(9'd71, 8'd255);
      offer_write(9'd72, 8'd1);
      offer_scan(3'd0);
      offer_scan(3'd7);
      offer_blank();
      offer_request(OP_UNUSED, 9'd511, 8'd255, 3'd7);
      offer_write(9'd0, 8'd255);
      offer_write(9'd319, 8'd0);
      offer_scan(3'd0);
      offer_scan(3'd7);
      offer_scan(3'd3);
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin source_idle_pct = 34; sink_idle_pct = 70; end
            1: begin source_idle_pct = 70; sink_idle_pct = 34; end
            default: begin source_idle_pct = 0; sink_idle_pct = 0; end
         endcase
         counted_items = 0;
         while (counted_items < PhaseItems) begin
            offer_random_item(counted);
            if (counted) counted_items++;
            // long receiver hold-off while scans keep coming
            if (phase == 2 && counted_items == PhaseItems / 2) begin
               stalls_asked++;
               for (int i = 0; i < StallBurst; i++) offer_scan(3'($urandom_range(7)));
               counted_items++;
            end
         end
         drain_results();
      end

      repeat (SettleCycles) @(posedge clock);
      if (mismatch_count == 0 && bytes_due == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/bclsu_pkg.sv
hw/rtl/bclsu_if.sv
hw/rtl/bclsu_front.sv
hw/rtl/bclsu_queue.sv
hw/rtl/bclsu_back.sv
hw/rtl/bicolor_led_matrix_column_scan_unit.sv
tb/column_frame_checker.sv
tb/tb_top.sv
